// ----- hw/rtl/bmu_pkg.sv -----
// Shared types, operation codes and lane helpers for the bit manipulation unit.
`timescale 1ns / 1ps
`default_nettype none

package bmu_pkg;

  // Operation codes carried in the kind field.
  localparam logic [4:0] KIND_POPCOUNT = 5'd0;
  localparam logic [4:0] KIND_LOWBIT   = 5'd1;
  localparam logic [4:0] KIND_HIGHBIT  = 5'd2;
  localparam logic [4:0] KIND_BSWAP16  = 5'd3;
  localparam logic [4:0] KIND_BSWAP64  = 5'd5;
  localparam logic [4:0] KIND_ROTR8    = 5'd6;
  localparam logic [4:0] KIND_ROTR64   = 5'd9;
  localparam logic [4:0] KIND_ROTL8    = 5'd10;
  localparam logic [4:0] KIND_ROTL64   = 5'd13;
  localparam logic [4:0] KIND_SHL8     = 5'd14;
  localparam logic [4:0] KIND_SHL64    = 5'd17;
  localparam logic [4:0] KIND_SHR32    = 5'd18;
  localparam logic [4:0] KIND_SHR64    = 5'd19;
  localparam logic [4:0] KIND_SAR32    = 5'd20;
  localparam logic [4:0] KIND_SAR64    = 5'd21;

  localparam int WORD_W  = 64;
  localparam int DIST_W  = 8;
  localparam int BYTES   = WORD_W / 8;

  // Lane width codes.
  localparam logic [1:0] LANE_8  = 2'd0;
  localparam logic [1:0] LANE_16 = 2'd1;
  localparam logic [1:0] LANE_32 = 2'd2;
  localparam logic [1:0] LANE_64 = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_POPCNT,
    OP_LOWBIT,
    OP_HIGHBIT,
    OP_BSWAP,
    OP_ROTATE,
    OP_SHIFT
  } op_class_t;

  // Decoded operation held in the first pipeline stage.
  typedef struct packed {
    op_class_t   cls;
    logic [1:0]  lane;
    logic [5:0]  rot_k;
    logic        left;
    logic        sar_right;
    logic [7:0]  mag;
  } decode_t;

  function automatic logic [WORD_W-1:0] lane_mask(input logic [1:0] lane);
    logic [WORD_W-1:0] m;
    case (lane)
      LANE_8:  m = 64'h0000_0000_0000_00FF;
      LANE_16: m = 64'h0000_0000_0000_FFFF;
      LANE_32: m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] rot_mask(input logic [1:0] lane);
    logic [5:0] m;
    case (lane)
      LANE_8:  m = 6'h07;
      LANE_16: m = 6'h0F;
      LANE_32: m = 6'h1F;
      default: m = 6'h3F;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bit_manipulation_unit.sv -----
// Top level of the bit manipulation unit: a three-stage pipelined 64-bit bit ALU.
`timescale 1ns / 1ps
`default_nettype none

// The bit manipulation unit takes one transaction per cycle on its slave stream and returns
// one 64-bit result per transaction on its master stream, in order. Each transaction carries
// an operation in s_tuser and a 64-bit operand plus a signed 8-bit distance in s_tdata. The
// operations are population count, 1-based lowest and highest set bit (zero for a zero
// operand), byte swaps of the low 16, 32 or 64 bits, rotates right and left and shifts of an
// 8, 16, 32 or 64-bit lane, logical right shifts and arithmetic right shifts of a 32 or
// 64-bit lane. Lane operations leave the bits above the lane untouched; a negative distance
// reverses the direction, and a shift by at least the lane width clears the lane or, for an
// arithmetic right shift, fills it with its sign. Unused codes return zero. The pipeline has
// three register stages (decode, lane shifters and per-byte counts, final combine into the
// output register), and the sustained rate is one transaction per clock while m_tready is
// high. Each stage moves on whenever the stage after it is free or is itself moving on, so
// the unit keeps accepting while a result waits at the output until the pipeline is full,
// and a stall on m_tready fills the pipeline without losing anything.
module bit_manipulation_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,   // [63:0] operand, [71:64] distance (signed)
  input  wire logic [4:0]  s_tuser,   // [4:0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata    // [63:0] result
);

  localparam int W = bmu_pkg::WORD_W;
  localparam int NB = bmu_pkg::BYTES;

  // Handshake chain: a stage loads when it is empty or its content moves on.
  logic out_load, s2_load, s1_load;
  logic v1, v2;

  assign out_load = !m_tvalid || m_tready;
  assign s2_load  = !v2 || out_load;
  assign s1_load  = !v1 || s2_load;
  assign s_tready = s1_load;

  // ------------------------------------------------------------------
  // Stage 1: decode the operation.
  // ------------------------------------------------------------------
  logic [4:0]        in_kind;
  logic [W-1:0]      in_operand;
  logic [7:0]        in_dist;
  logic [7:0]        dist_neg;
  logic [5:0]        raw_k;
  bmu_pkg::decode_t  dec;

  assign in_kind    = s_tuser;
  assign in_operand = s_tdata[63:0];
  assign in_dist    = s_tdata[71:64];
  assign dist_neg   = 8'(-in_dist);

  always_comb begin
    dec.cls       = bmu_pkg::OP_NONE;
    dec.lane      = bmu_pkg::LANE_64;
    dec.left      = 1'b0;
    dec.sar_right = 1'b0;
    dec.mag       = in_dist[7] ? dist_neg : in_dist;
    raw_k         = in_dist[5:0];
    case (in_kind) inside
      bmu_pkg::KIND_POPCOUNT: begin
        dec.cls = bmu_pkg::OP_POPCNT;
      end
      bmu_pkg::KIND_LOWBIT: begin
        dec.cls = bmu_pkg::OP_LOWBIT;
      end
      bmu_pkg::KIND_HIGHBIT: begin
        dec.cls = bmu_pkg::OP_HIGHBIT;
      end
      [bmu_pkg::KIND_BSWAP16:bmu_pkg::KIND_BSWAP64]: begin
        dec.cls  = bmu_pkg::OP_BSWAP;
        dec.lane = 2'(in_kind - bmu_pkg::KIND_BSWAP16 + 5'd1);
      end
      [bmu_pkg::KIND_ROTR8:bmu_pkg::KIND_ROTR64]: begin
        dec.cls  = bmu_pkg::OP_ROTATE;
        dec.lane = 2'(in_kind - bmu_pkg::KIND_ROTR8);
      end
      [bmu_pkg::KIND_ROTL8:bmu_pkg::KIND_ROTL64]: begin
        // A left rotate is a right rotate by the negated distance.
        dec.cls  = bmu_pkg::OP_ROTATE;
        dec.lane = 2'(in_kind - bmu_pkg::KIND_ROTL8);
        raw_k    = dist_neg[5:0];
      end
      [bmu_pkg::KIND_SHL8:bmu_pkg::KIND_SHL64]: begin
        dec.cls  = bmu_pkg::OP_SHIFT;
        dec.lane = 2'(in_kind - bmu_pkg::KIND_SHL8);
        dec.left = !in_dist[7];
      end
      [bmu_pkg::KIND_SHR32:bmu_pkg::KIND_SHR64]: begin
        dec.cls  = bmu_pkg::OP_SHIFT;
        dec.lane = 2'(in_kind - bmu_pkg::KIND_SHR32 + 5'd2);
        dec.left = in_dist[7];
      end
      [bmu_pkg::KIND_SAR32:bmu_pkg::KIND_SAR64]: begin
        // A negative distance turns this into a logical left shift.
        dec.cls       = bmu_pkg::OP_SHIFT;
        dec.lane      = 2'(in_kind - bmu_pkg::KIND_SAR32 + 5'd2);
        dec.left      = in_dist[7];
        dec.sar_right = !in_dist[7];
      end
      default: begin
        dec.cls = bmu_pkg::OP_NONE;
      end
    endcase
    dec.rot_k = raw_k & bmu_pkg::rot_mask(dec.lane);
  end

  bmu_pkg::decode_t s1_dec;
  logic [W-1:0]     s1_operand;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s1_load) begin
      v1 <= s_tvalid;
    end
    if (s1_load && s_tvalid) begin
      s1_dec     <= dec;
      s1_operand <= in_operand;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: lane shifters, byte swap and per-byte counts.
  // ------------------------------------------------------------------
  logic [W-1:0]  mask;
  logic [W-1:0]  x;
  logic          fill;
  logic [W-1:0]  ext;
  logic [W-1:0]  shr_v;
  logic [W-1:0]  shl_v;
  logic [15:0]   rot8_w;
  logic [31:0]   rot16_w;
  logic [63:0]   rot32_w;
  logic [127:0]  rot64_w;
  logic [W-1:0]  rot_v;
  logic [W-1:0]  swap_v;
  logic [W-1:0]  lane_v;
  logic [W-1:0]  lane_res;
  logic [3:0]    pc_byte  [NB];
  logic          lo_any   [NB];
  logic [2:0]    lo_pos   [NB];
  logic          hi_any   [NB];
  logic [2:0]    hi_pos   [NB];

  assign x     = s1_operand;
  assign mask  = bmu_pkg::lane_mask(s1_dec.lane);

  always_comb begin
    case (s1_dec.lane)
      bmu_pkg::LANE_8:  fill = s1_dec.sar_right && x[7];
      bmu_pkg::LANE_16: fill = s1_dec.sar_right && x[15];
      bmu_pkg::LANE_32: fill = s1_dec.sar_right && x[31];
      default:          fill = s1_dec.sar_right && x[63];
    endcase
  end

  // Bits above the lane carry the fill so the shift brings it in from the top of the lane.
  assign ext   = (x & mask) | (fill ? ~mask : '0);
  assign shr_v = fill ? W'($signed(ext) >>> s1_dec.mag) : (ext >> s1_dec.mag);
  assign shl_v = x << s1_dec.mag;

  assign rot8_w  = {x[7:0], x[7:0]} >> s1_dec.rot_k[2:0];
  assign rot16_w = {x[15:0], x[15:0]} >> s1_dec.rot_k[3:0];
  assign rot32_w = {x[31:0], x[31:0]} >> s1_dec.rot_k[4:0];
  assign rot64_w = {x, x} >> s1_dec.rot_k;

  always_comb begin
    case (s1_dec.lane)
      bmu_pkg::LANE_8:  rot_v = {56'd0, rot8_w[7:0]};
      bmu_pkg::LANE_16: rot_v = {48'd0, rot16_w[15:0]};
      bmu_pkg::LANE_32: rot_v = {32'd0, rot32_w[31:0]};
      default:          rot_v = rot64_w[63:0];
    endcase
  end

  always_comb begin
    swap_v = '0;
    case (s1_dec.lane)
      bmu_pkg::LANE_16: begin
        swap_v[15:0] = {x[7:0], x[15:8]};
      end
      bmu_pkg::LANE_32: begin
        swap_v[31:0] = {x[7:0], x[15:8], x[23:16], x[31:24]};
      end
      default: begin
        for (int i = 0; i < NB; i++) begin
          swap_v[8*i +: 8] = x[8*(NB-1-i) +: 8];
        end
      end
    endcase
  end

  always_comb begin
    case (s1_dec.cls)
      bmu_pkg::OP_BSWAP:  lane_v = swap_v;
      bmu_pkg::OP_ROTATE: lane_v = rot_v;
      bmu_pkg::OP_SHIFT:  lane_v = s1_dec.left ? shl_v : shr_v;
      default:            lane_v = x;
    endcase
    lane_res = (x & ~mask) | (lane_v & mask);
  end

  always_comb begin
    for (int b = 0; b < NB; b++) begin
      pc_byte[b] = '0;
      lo_pos[b]  = '0;
      hi_pos[b]  = '0;
      lo_any[b]  = |x[8*b +: 8];
      hi_any[b]  = |x[8*b +: 8];
      for (int i = 0; i < 8; i++) begin
        pc_byte[b] = pc_byte[b] + 4'(x[8*b + i]);
      end
      for (int i = 7; i >= 0; i--) begin
        if (x[8*b + i]) begin
          lo_pos[b] = 3'(i);
        end
      end
      for (int i = 0; i < 8; i++) begin
        if (x[8*b + i]) begin
          hi_pos[b] = 3'(i);
        end
      end
    end
  end

  bmu_pkg::op_class_t s2_cls;
  logic [W-1:0]       s2_lane;
  logic [3:0]         s2_pc    [NB];
  logic               s2_lo_any[NB];
  logic [2:0]         s2_lo_pos[NB];
  logic               s2_hi_any[NB];
  logic [2:0]         s2_hi_pos[NB];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s2_load) begin
      v2 <= v1;
    end
    if (s2_load && v1) begin
      s2_cls  <= s1_dec.cls;
      s2_lane <= lane_res;
      for (int b = 0; b < NB; b++) begin
        s2_pc[b]     <= pc_byte[b];
        s2_lo_any[b] <= lo_any[b];
        s2_lo_pos[b] <= lo_pos[b];
        s2_hi_any[b] <= hi_any[b];
        s2_hi_pos[b] <= hi_pos[b];
      end
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: combine byte counts and select the result.
  // ------------------------------------------------------------------
  logic [6:0]   pc_sum;
  logic [6:0]   lo_idx;
  logic [6:0]   hi_idx;
  logic [W-1:0] result_next;

  always_comb begin
    pc_sum = '0;
    lo_idx = '0;
    hi_idx = '0;
    for (int b = 0; b < NB; b++) begin
      pc_sum = pc_sum + 7'(s2_pc[b]);
    end
    for (int b = NB - 1; b >= 0; b--) begin
      if (s2_lo_any[b]) begin
        lo_idx = {3'(b), s2_lo_pos[b]} + 7'd1;
      end
    end
    for (int b = 0; b < NB; b++) begin
      if (s2_hi_any[b]) begin
        hi_idx = {3'(b), s2_hi_pos[b]} + 7'd1;
      end
    end
    case (s2_cls)
      bmu_pkg::OP_POPCNT:  result_next = {57'd0, pc_sum};
      bmu_pkg::OP_LOWBIT:  result_next = {57'd0, lo_idx};
      bmu_pkg::OP_HIGHBIT: result_next = {57'd0, hi_idx};
      bmu_pkg::OP_BSWAP,
      bmu_pkg::OP_ROTATE,
      bmu_pkg::OP_SHIFT:   result_next = s2_lane;
      default:             result_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= v2;
    end
    if (out_load && v2) begin
      m_tdata <= result_next;
    end
  end

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_ready_when_out_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled although the output register is free");

  a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    v1 && !s2_load |=> v1 && $stable(s1_operand) && $stable(s1_dec))
    else $error("stage 1 changed while stalled");

  a_popcount_range: assert property (@(posedge clk) disable iff (rst)
    out_load && v2 && s2_cls == bmu_pkg::OP_POPCNT
    |=> m_tdata[63:7] == '0 && m_tdata[6:0] <= 7'd64)
    else $error("population count out of range");

  a_out_from_stage2: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(v2))
    else $error("result appeared without a transaction in stage 2");

endmodule

`default_nettype wire

// ----- bench/tb_bit_manipulation_unit.sv -----
// Self-checking testbench for the bit manipulation unit, with directed and random transactions.
`timescale 1ns / 1ps

module tb_bit_manipulation_unit;

  // Operation codes that the package does not name.
  localparam logic [4:0] KIND_BSWAP32      = 5'd4;
  localparam logic [4:0] KIND_ROTR16       = 5'd7;
  localparam logic [4:0] KIND_ROTR32       = 5'd8;
  localparam logic [4:0] KIND_SHL32        = 5'd16;
  localparam logic [4:0] KIND_FIRST_UNUSED = 5'd22;
  localparam logic [4:0] KIND_LAST_UNUSED  = 5'd31;

  localparam logic [63:0]        ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0]        TOP_BIT     = 64'h8000_0000_0000_0000;
  localparam logic [63:0]        SAMPLE_WORD = 64'h0123_4567_89AB_CDEF;
  localparam logic signed [7:0]  DIST_MIN    = 8'sh80;  // most negative distance

  localparam int DIRECTED_COUNT = 25;
  localparam int RANDOM_ITEMS   = 650;
  localparam int BLOCK_ITEMS    = 50;    // random items per stretch, idling or back to back
  localparam int MAX_GAP        = 13;
  localparam int PRESSURE_POINT = 120;   // results taken before the long hold-off
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;   // [63:0] operand, [71:64] distance (signed)
  logic [4:0]  s_tuser = '0;   // [4:0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // [63:0] result

  logic [63:0] pending_results [$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;

  bit_manipulation_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Predictor of the unit.
  // ------------------------------------------------------------------
  function automatic logic [63:0] lane_bits(input int width);
    return (width >= 64) ? ALL_ONES : ((64'd1 << width) - 64'd1);
  endfunction

  // Logical shift of the low lane: left for a positive distance, right for a negative one.
  function automatic logic [63:0] shift_lane(input logic [63:0] word, input int width,
                                             input int shift_by);
    logic [63:0] mask;
    logic [63:0] lane;
    int          mag;
    mask = lane_bits(width);
    lane = word & mask;
    mag  = (shift_by < 0) ? -shift_by : shift_by;
    if (shift_by == 0) return word;
    if (mag >= width) lane = '0;
    else if (shift_by < 0) lane = lane >> mag;
    else lane = (lane << mag) & mask;
    return (word & ~mask) | lane;
  endfunction

  function automatic logic [63:0] rotate_lane(input logic [63:0] word, input int width,
                                              input int shift_by, input bit right);
    logic [63:0] mask;
    logic [63:0] lane;
    int          amount;
    mask   = lane_bits(width);
    lane   = word & mask;
    amount = shift_by % width;
    if (amount < 0) amount += width;
    if (!right && amount != 0) amount = width - amount;
    if (amount != 0) lane = ((lane >> amount) | (lane << (width - amount))) & mask;
    return (word & ~mask) | lane;
  endfunction

  // Arithmetic right shift of the low lane, left if negative; the sign fill never leaves it.
  function automatic logic [63:0] sar_lane(input logic [63:0] word, input int width,
                                           input int shift_by);
    logic [63:0] mask;
    logic [63:0] lane;
    logic        negative;
    mask     = lane_bits(width);
    lane     = word & mask;
    negative = lane[width-1];
    if (shift_by == 0) return word;
    if (shift_by < 0) return shift_lane(word, width, -shift_by);
    if (shift_by >= width) lane = negative ? mask : '0;
    else lane = (lane >> shift_by) | (negative ? (mask & ~(mask >> shift_by)) : 64'd0);
    return (word & ~mask) | lane;
  endfunction

  function automatic logic [63:0] predict_result(input logic [4:0] kind,
                                                 input logic [63:0] word,
                                                 input logic signed [7:0] distance);
    logic [63:0] res;
    logic [63:0] mask;
    int          shift_by;
    int          nbytes;
    shift_by = distance;
    res      = '0;
    if (kind == bmu_pkg::KIND_POPCOUNT) begin
      res = 64'($countones(word));
    end else if (kind == bmu_pkg::KIND_LOWBIT) begin
      for (int i = 63; i >= 0; i--) if (word[i]) res = 64'(i + 1);
    end else if (kind == bmu_pkg::KIND_HIGHBIT) begin
      for (int i = 0; i < 64; i++) if (word[i]) res = 64'(i + 1);
    end else if (kind <= bmu_pkg::KIND_BSWAP64) begin
      nbytes = 2 << (kind - bmu_pkg::KIND_BSWAP16);
      mask   = lane_bits(8 * nbytes);
      res    = word & ~mask;
      for (int i = 0; i < nbytes; i++) res[8*(nbytes-1-i) +: 8] = word[8*i +: 8];
    end else if (kind <= bmu_pkg::KIND_ROTR64) begin
      res = rotate_lane(word, 8 << (kind - bmu_pkg::KIND_ROTR8), shift_by, 1'b1);
    end else if (kind <= bmu_pkg::KIND_ROTL64) begin
      res = rotate_lane(word, 8 << (kind - bmu_pkg::KIND_ROTL8), shift_by, 1'b0);
    end else if (kind <= bmu_pkg::KIND_SHL64) begin
      res = shift_lane(word, 8 << (kind - bmu_pkg::KIND_SHL8), shift_by);
    end else if (kind <= bmu_pkg::KIND_SHR64) begin
      // A positive distance shifts right; with int arithmetic the most negative
      // distance simply becomes a left shift by 128, which clears the lane.
      res = shift_lane(word, 32 << (kind - bmu_pkg::KIND_SHR32), -shift_by);
    end else if (kind <= bmu_pkg::KIND_SAR64) begin
      res = sar_lane(word, 32 << (kind - bmu_pkg::KIND_SAR32), shift_by);
    end
    return res;
  endfunction

  // ------------------------------------------------------------------
  // Directed table. Rows with has_expected set carry a result that can be
  // read straight off the operation; the others go through the predictor.
  // ------------------------------------------------------------------
  typedef struct packed {
    logic [4:0]        kind;
    logic [63:0]       operand;
    logic signed [7:0] distance;
    logic              has_expected;
    logic [63:0]       expected;
  } directed_row_t;

  directed_row_t directed_rows [0:DIRECTED_COUNT-1] = '{
    '{bmu_pkg::KIND_POPCOUNT, 64'd0,       8'sd0,    1'b1, 64'd0},
    '{bmu_pkg::KIND_POPCOUNT, ALL_ONES,    8'sd0,    1'b1, 64'd64},
    '{bmu_pkg::KIND_LOWBIT,   64'd0,       8'sd5,    1'b1, 64'd0},
    '{bmu_pkg::KIND_LOWBIT,   TOP_BIT,     8'sd0,    1'b1, 64'd64},
    '{bmu_pkg::KIND_HIGHBIT,  64'd0,       8'sd0,    1'b1, 64'd0},
    '{bmu_pkg::KIND_HIGHBIT,  ALL_ONES,    8'sd0,    1'b1, 64'd64},
    '{bmu_pkg::KIND_HIGHBIT,  64'd1,       8'sd0,    1'b1, 64'd1},
    '{bmu_pkg::KIND_BSWAP16,  SAMPLE_WORD, 8'sd0,    1'b1, 64'h0123_4567_89AB_EFCD},
    '{KIND_BSWAP32,           SAMPLE_WORD, 8'sd0,    1'b1, 64'h0123_4567_EFCD_AB89},
    '{bmu_pkg::KIND_BSWAP64,  SAMPLE_WORD, DIST_MIN, 1'b1, 64'hEFCD_AB89_6745_2301},
    '{bmu_pkg::KIND_ROTR8,    SAMPLE_WORD, -8'sd1,   1'b0, 64'd0},
    '{KIND_ROTR16,            SAMPLE_WORD, 8'sd127,  1'b0, 64'd0},
    '{KIND_ROTR32,            SAMPLE_WORD, DIST_MIN, 1'b0, 64'd0},
    '{bmu_pkg::KIND_ROTL64,   SAMPLE_WORD, 8'sd127,  1'b0, 64'd0},
    '{bmu_pkg::KIND_ROTL8,    SAMPLE_WORD, 8'sd0,    1'b1, SAMPLE_WORD},
    '{bmu_pkg::KIND_SHL8,     ALL_ONES,    8'sd8,    1'b1, 64'hFFFF_FFFF_FFFF_FF00},
    '{KIND_SHL32,             SAMPLE_WORD, -8'sd5,   1'b0, 64'd0},
    '{bmu_pkg::KIND_SHL64,    SAMPLE_WORD, 8'sd0,    1'b1, SAMPLE_WORD},
    '{bmu_pkg::KIND_SHR32,    ALL_ONES,    DIST_MIN, 1'b1, 64'hFFFF_FFFF_0000_0000},
    '{bmu_pkg::KIND_SHR64,    ALL_ONES,    8'sd127,  1'b1, 64'd0},
    '{bmu_pkg::KIND_SAR32,    64'h0000_0000_8000_0000, 8'sd40, 1'b1,
      64'h0000_0000_FFFF_FFFF},
    '{bmu_pkg::KIND_SAR32,    64'h1234_5678_8765_4321, 8'sd4,  1'b0, 64'd0},
    '{bmu_pkg::KIND_SAR64,    SAMPLE_WORD, -8'sd3,   1'b0, 64'd0},
    '{bmu_pkg::KIND_SAR64,    TOP_BIT,     8'sd127,  1'b1, ALL_ONES},
    '{KIND_LAST_UNUSED,       ALL_ONES,    8'sd1,    1'b1, 64'd0}
  };

  // ------------------------------------------------------------------
  // Random field draws.
  // ------------------------------------------------------------------
  function automatic logic [4:0] draw_kind();
    if ($urandom_range(0, 99) < 8)
      return 5'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_UNUSED));
    return 5'($urandom_range(bmu_pkg::KIND_POPCOUNT, bmu_pkg::KIND_SAR64));
  endfunction

  function automatic logic [63:0] draw_operand();
    case ($urandom_range(0, 5))
      3:       return 64'd1 << $urandom_range(0, 63);
      4:       return $urandom_range(0, 1) ? ALL_ONES : 64'd0;
      5:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Distances cluster around the lane widths so the clearing and sign-fill
  // boundaries are crossed often.
  function automatic logic signed [7:0] draw_distance();
    logic signed [7:0] drawn;
    case ($urandom_range(0, 3))
      0: drawn = 8'($urandom);
      1: drawn = 8'($urandom_range(0, 16));
      2: drawn = 8'((8 << $urandom_range(0, 3)) + $urandom_range(0, 2) - 1);
      default: begin
        case ($urandom_range(0, 3))
          0:       drawn = 8'sd0;
          1:       drawn = 8'sd127;
          2:       drawn = DIST_MIN;
          default: drawn = 8'sd1;
        endcase
      end
    endcase
    if ($urandom_range(0, 1) && drawn != DIST_MIN) drawn = -drawn;
    return drawn;
  endfunction

  // ------------------------------------------------------------------
  // Sender: starts at a falling edge, ends at the rising edge of acceptance.
  // ------------------------------------------------------------------
  task automatic send_operation(input logic [4:0] kind, input logic [63:0] operand,
                                input logic signed [7:0] distance, input bit has_expected,
                                input logic [63:0] expected, input bit no_idle);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {distance, operand};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(has_expected ? expected
                                           : predict_result(kind, operand, distance));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_operation(directed_rows[i].kind, directed_rows[i].operand,
                     directed_rows[i].distance, directed_rows[i].has_expected,
                     directed_rows[i].expected, 1'b0);
    end

    // Every third stretch of random items is sent back to back.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_operation(draw_kind(), draw_operand(), draw_distance(), 1'b0, 64'd0,
                     ((i / BLOCK_ITEMS) % 3) == 1);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[bit_manipulation_unit] OK");
    end else begin
      $display("[bit_manipulation_unit] ERROR");
    end
    $finish;
  end

  // ------------------------------------------------------------------
  // Receiver: random ready gaps, stretches without gaps, and one long
  // hold-off that backs the pipeline up into its input.
  // ------------------------------------------------------------------
  initial begin
    int taken;
    int hold;
    taken = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (taken == PRESSURE_POINT) hold = HOLD_CYCLES;
      else if (((taken / 80) % 3) == 2) hold = 0;
      else hold = $urandom_range(0, MAX_GAP);
      if (hold != 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  // Result checker: each result transaction is matched with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result transaction, expected none, actual %h",
                 $realtime, m_tdata);
      end else if (m_tdata !== pending_results[0]) begin
        mismatch_count++;
        $display("%0t: result mismatch, expected %h, actual %h",
                 $realtime, pending_results[0], m_tdata);
        void'(pending_results.pop_front());
      end else begin
        void'(pending_results.pop_front());
      end
    end
  end

  // Watchdog on cycles in which neither side completes a transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("[bit_manipulation_unit] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
